### hw/rtl/rts_pkg.sv
// Shared types and constants for the RPM threshold sequencer.
`timescale 1ns / 1ps

package rts_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] time_ms;
        logic        pulse_level;
    } rts_in_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] window_pulses;
    } rts_out_t;

    // Request modes
    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_RESET  = 2'd2;

    // Reported phase codes
    localparam logic [1:0] PHASE_READY  = 2'd0;
    localparam logic [1:0] PHASE_WAIT   = 2'd1;
    localparam logic [1:0] PHASE_COUNT  = 2'd2;
    localparam logic [1:0] PHASE_SIGNAL = 2'd3;

    // Internal one-hot phase state
    typedef enum logic [3:0] {
        PH_READY  = 4'b0001,
        PH_WAIT   = 4'b0010,
        PH_COUNT  = 4'b0100,
        PH_SIGNAL = 4'b1000
    } rts_phase_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR         = 2'd2;

    // Timing constants, milliseconds
    localparam logic [31:0] WINDOW_MS = 32'd1000;
    localparam logic [31:0] SIGNAL_MS = 32'd3000;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Configuration handed to the core
    typedef struct packed {
        logic [31:0] start_delay_ms;
        logic [23:0] limit_product;   // rpm_threshold * pulses_per_rev
    } rts_cfg_t;

endpackage

### hw/rtl/rpm_threshold_sequencer.sv
// Top level of the RPM threshold sequencer: request and result stages.
`timescale 1ns / 1ps

// Channel   Direction  Payload                              Handshake
// s_        in         mode, time_ms, pulse_level           s_valid / s_ready
// m_        out        phase, window_pulses                 m_valid / m_ready
// cfg_      in         start_delay_ms, rpm_threshold, ppr   cfg_we, no wait
//
// Request, then result register; one request per cycle while m_ready is high.
// The phase/stamp/count update is a single pass between the request register and
// the result register, so the state registers load with each advancing request.
// Reset (aresetn low, synchronous) clears both stages, the phase state and config, but sets ppr to 1.
// A stalled result holds the request register; s_ready drops only when both are full.
// The limit product is registered from the configuration registers after a write.

module rpm_threshold_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rts_pkg::rts_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rts_pkg::rts_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [rts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata
);

    rts_pkg::rts_cfg_t cfg;
    rts_pkg::rts_in_t  req_reg;
    rts_pkg::rts_out_t res_reg;
    rts_pkg::rts_out_t result;
    logic              req_valid_reg;
    logic              res_valid_reg;
    logic              advance;

    // request moves into the result stage when that stage is free or draining
    assign advance = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;

    rts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_out   (cfg)
    );

    rts_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // request stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

`ifndef SYNTHESIS
    // backpressure only when both stages are occupied and the result is stalled
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> req_valid_reg && res_valid_reg && !m_ready)
        else $error("request stage stalled without cause");

    // an advancing request always yields a result next cycle
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> res_valid_reg)
        else $error("result lost after advance");

    // a stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && !m_ready |-> !advance)
        else $error("stalled result overwritten");
`endif

endmodule

### hw/rtl/rts_cfg.sv
// Configuration registers and the precomputed speed limit product.
`timescale 1ns / 1ps

module rts_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_wdata,
    output rts_pkg::rts_cfg_t              cfg_out
);

    logic [31:0] start_delay_reg;
    logic [15:0] threshold_reg;
    logic [7:0]  ppr_reg;
    logic [23:0] product_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg <= 32'd0;
            threshold_reg   <= 16'd0;
            ppr_reg         <= 8'd1;
            product_reg     <= 24'd0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rts_pkg::CFG_START_DELAY: start_delay_reg <= cfg_wdata;
                    rts_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_wdata[15:0];
                    rts_pkg::CFG_PPR:         ppr_reg         <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // 16x8 product, registered from the configuration registers
            product_reg <= {8'd0, threshold_reg} * {16'd0, ppr_reg};
        end
    end

    assign cfg_out.start_delay_ms = start_delay_reg;
    assign cfg_out.limit_product  = product_reg;

endmodule

### hw/rtl/rts_core.sv
// Phase state, window counter and per-request next-state logic.
`timescale 1ns / 1ps

module rts_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  rts_pkg::rts_in_t    req,
    input  rts_pkg::rts_cfg_t   cfg,
    output rts_pkg::rts_out_t   result
);

    rts_pkg::rts_phase_t phase_reg, phase_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] count_reg, count_next;
    logic        prior_reg, prior_next;

    logic [31:0] span;
    logic [31:0] diff;
    logic        elapsed;
    logic [15:0] count_inc;
    logic [21:0] lhs;
    logic        slow;

    always_comb begin
        case (phase_reg)
            rts_pkg::PH_WAIT:   span = cfg.start_delay_ms;
            rts_pkg::PH_COUNT:  span = rts_pkg::WINDOW_MS;
            default:            span = rts_pkg::SIGNAL_MS;
        endcase
        diff    = req.time_ms - stamp_reg;
        elapsed = diff >= span;

        count_inc = count_reg;
        if (!prior_reg && req.pulse_level && count_reg != rts_pkg::COUNT_MAX) begin
            count_inc = count_reg + 16'd1;
        end
        // count * 60 = count * 64 - count * 4
        lhs  = {count_inc, 6'd0} - {4'd0, count_inc, 2'd0};
        slow = {2'd0, lhs} <= cfg.limit_product;
    end

    always_comb begin
        phase_next = phase_reg;
        stamp_next = stamp_reg;
        count_next = count_reg;
        prior_next = prior_reg;
        case (req.mode)
            rts_pkg::MODE_UPDATE: begin
                prior_next = req.pulse_level;
                case (phase_reg)
                    rts_pkg::PH_WAIT: begin
                        if (elapsed) begin
                            stamp_next = req.time_ms;
                            count_next = 16'd0;
                            phase_next = rts_pkg::PH_COUNT;
                        end
                    end
                    rts_pkg::PH_COUNT: begin
                        count_next = count_inc;
                        if (elapsed) begin
                            stamp_next = req.time_ms;
                            if (slow) begin
                                phase_next = rts_pkg::PH_SIGNAL;
                            end else begin
                                count_next = 16'd0;
                            end
                        end
                    end
                    rts_pkg::PH_SIGNAL: begin
                        if (elapsed) begin
                            phase_next = rts_pkg::PH_READY;
                        end
                    end
                    default: ;
                endcase
            end
            rts_pkg::MODE_START: begin
                if (phase_reg == rts_pkg::PH_READY) begin
                    stamp_next = req.time_ms;
                    phase_next = rts_pkg::PH_WAIT;
                end
            end
            rts_pkg::MODE_RESET: begin
                phase_next = rts_pkg::PH_READY;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rts_pkg::PH_READY;
            stamp_reg <= 32'd0;
            count_reg <= 16'd0;
            prior_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            stamp_reg <= stamp_next;
            count_reg <= count_next;
            prior_reg <= prior_next;
        end
    end

    always_comb begin
        case (phase_next)
            rts_pkg::PH_WAIT:   result.phase = rts_pkg::PHASE_WAIT;
            rts_pkg::PH_COUNT:  result.phase = rts_pkg::PHASE_COUNT;
            rts_pkg::PH_SIGNAL: result.phase = rts_pkg::PHASE_SIGNAL;
            default:            result.phase = rts_pkg::PHASE_READY;
        endcase
        result.window_pulses = count_next;
    end

`ifndef SYNTHESIS
    // counter moves by one edge at most, or clears
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == $past(count_reg) || count_reg == 16'd0
        || count_reg == $past(count_reg) + 16'd1)
        else $error("edge count jumped");

    // signaling is entered only from counting
    a_signal_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == rts_pkg::PH_SIGNAL && $past(phase_reg) != rts_pkg::PH_SIGNAL
        |-> $past(phase_reg) == rts_pkg::PH_COUNT)
        else $error("signaling entered outside counting");

    // state holds when no request is applied
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg) && $stable(stamp_reg) && $stable(count_reg))
        else $error("state changed without a request");
`endif

endmodule
